>>> hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Shared types and constants for the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int LengthWidthDef = 64;
  localparam int QueueDepth     = 4;
  localparam logic [3:0] OpcClose = 4'h8;
  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT16, PH_EXT64, PH_KEY, PH_PAYLOAD, PH_TRAIL
  } phase_e;

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0, ST_INCOMPLETE = 2'd1, ST_CLOSE = 2'd2
  } status_e;

endpackage

>>> hdl/wsd_front.sv
// ----------------------------------------------------------------------------
// Deframer front end
// Parses header bytes and forms one result request per payload or last byte.
// ----------------------------------------------------------------------------
module wsd_front import wsd_pkg::*; #(
  parameter int LengthWidth = LengthWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [7:0]             in_byte_i,
  input  logic                   in_eob_i,
  output logic                   in_ready_o,
  output logic                   req_valid_o,
  input  logic                   req_ready_i,
  output logic [LengthWidth+16:0] req_data_o
);

  phase_e                 phase_q, phase_d;
  logic                   fin_q, fin_d, masked_q, masked_d, close_q, close_d;
  logic [3:0]             opc_q, opc_d;
  logic [LengthWidth-1:0] len_q, len_d, pcnt_q, pcnt_d, pinc;
  logic [2:0]             hcnt_q, hcnt_d;
  logic [31:0]            key_q, key_d;
  logic                   emit, fire;
  logic [7:0]             ob, kb;
  status_e                st;

  assign in_ready_o = req_ready_i;
  assign fire       = in_valid_i && req_ready_i;
  assign pinc       = pcnt_q + 1'b1;

  always_comb begin
    case (pcnt_q[1:0])
      2'd0:    kb = key_q[31:24];
      2'd1:    kb = key_q[23:16];
      2'd2:    kb = key_q[15:8];
      default: kb = key_q[7:0];
    endcase
  end

  // Parse one byte.
  always_comb begin
    phase_d = phase_q; fin_d = fin_q; masked_d = masked_q; close_d = close_q;
    opc_d = opc_q; len_d = len_q; pcnt_d = pcnt_q; hcnt_d = hcnt_q; key_d = key_q;
    emit = 1'b0; ob = 8'd0; st = ST_COMPLETE;
    case (phase_q)
      PH_HDR0: begin
        fin_d = in_byte_i[7];
        opc_d = in_byte_i[3:0];
        if (!in_eob_i) begin
          if (in_byte_i[3:0] == OpcClose) begin
            close_d = 1'b1; phase_d = PH_TRAIL;
          end else begin
            phase_d = PH_HDR1;
          end
        end
      end
      PH_HDR1: begin
        masked_d = in_byte_i[7];
        hcnt_d   = 3'd0;
        if (in_byte_i[6:0] == LenExt16) begin
          len_d = '0; phase_d = PH_EXT16;
        end else if (in_byte_i[6:0] == LenExt64) begin
          len_d = '0; phase_d = PH_EXT64;
        end else begin
          len_d = LengthWidth'(in_byte_i[6:0]);
          if (in_byte_i[7]) phase_d = PH_KEY;
          else if (in_byte_i[6:0] == 7'd0) phase_d = PH_TRAIL;
          else phase_d = PH_PAYLOAD;
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_d = {len_q[LengthWidth-9:0], in_byte_i};
        if (hcnt_q == ((phase_q == PH_EXT16) ? 3'd1 : 3'd7)) begin
          hcnt_d = 3'd0;
          if (masked_q) phase_d = PH_KEY;
          else if (len_d == '0) phase_d = PH_TRAIL;
          else phase_d = PH_PAYLOAD;
        end else begin
          hcnt_d = hcnt_q + 3'd1;
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], in_byte_i};
        if (hcnt_q == 3'd3) begin
          hcnt_d  = 3'd0;
          phase_d = (len_q == '0) ? PH_TRAIL : PH_PAYLOAD;
        end else begin
          hcnt_d = hcnt_q + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        emit   = 1'b1;
        ob     = masked_q ? (in_byte_i ^ kb) : in_byte_i;
        pcnt_d = pinc;
        if (pinc == len_q) phase_d = PH_TRAIL;
      end
      default: ;
    endcase
    // Status for the buffer's last byte.
    if (in_eob_i) begin
      if (phase_q == PH_HDR0) st = ST_INCOMPLETE;
      else if (close_d) st = ST_CLOSE;
      else st = (phase_d == PH_TRAIL) ? ST_COMPLETE : ST_INCOMPLETE;
    end
  end

  assign req_valid_o = in_valid_i && (emit || in_eob_i);
  // Fields from the lowest bit: byte, has_byte, done, status, fin, opcode, length.
  assign req_data_o  = {len_d, opc_d, fin_d, st, in_eob_i, emit, ob};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0; fin_q <= 1'b0; masked_q <= 1'b0; close_q <= 1'b0;
      opc_q <= '0; len_q <= '0; pcnt_q <= '0; hcnt_q <= '0; key_q <= '0;
    end else if (fire) begin
      if (in_eob_i) begin
        phase_q <= PH_HDR0; fin_q <= 1'b0; masked_q <= 1'b0; close_q <= 1'b0;
        opc_q <= '0; len_q <= '0; pcnt_q <= '0; hcnt_q <= '0; key_q <= '0;
      end else begin
        phase_q <= phase_d; fin_q <= fin_d; masked_q <= masked_d; close_q <= close_d;
        opc_q <= opc_d; len_q <= len_d; pcnt_q <= pcnt_d; hcnt_q <= hcnt_d;
        key_q <= key_d;
      end
    end
  end

endmodule

>>> hdl/wsd_queue.sv
// ----------------------------------------------------------------------------
// Deframer result queue
// Small register FIFO between the parser and the output port.
// ----------------------------------------------------------------------------
module wsd_queue import wsd_pkg::*; #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int Aw = $clog2(QueueDepth);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [Aw-1:0]    wp_q, rp_q;
  logic [Aw:0]      cnt_q;
  logic             wr, rd;

  assign wr_ready_o = (cnt_q != (Aw+1)'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end

endmodule

>>> hdl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// Frame deframer
// Decodes received frame bytes and delivers unmasked payload and status.
// ----------------------------------------------------------------------------
// Input: one buffer byte per request on s_axis; tlast marks the last byte.
// Output: a request for every payload byte and for the buffer's last byte,
// carrying the byte, status, FIN, opcode and decoded length in tdata, with
// tuser flagging a payload byte and tlast marking the last-byte result.
// Header, length and masking-key bytes give no output request.
// The parser takes one byte per cycle while the queue has room; each result
// leaves through a four-entry queue whose occupancy sets when input stalls.
// Sustained rate is one byte per cycle while m_axis_tready stays high.
// When the receiver stalls, the queue fills and s_axis_tready falls once
// it is full; nothing is dropped.
// Reset clears the parse state and empties the queue. After each last byte
// the parse state returns to its reset values for the next buffer.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int LengthWidth = LengthWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], status[9:8], fin[10], opcode[14:11], frame length[78:15]
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tuser,   // has_byte
  output logic        m_axis_tlast    // done_res
);

  localparam int Rw = LengthWidth + 17;

  logic          req_valid, req_ready, q_valid;
  logic [Rw-1:0] req_data, q_data;

  wsd_front #(.LengthWidth(LengthWidth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_byte_i(s_axis_tdata), .in_eob_i(s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_data_o(req_data)
  );

  wsd_queue #(.Width(Rw)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(req_valid), .wr_ready_o(req_ready), .wr_data_i(req_data),
    .rd_valid_o(q_valid), .rd_ready_i(m_axis_tready), .rd_data_o(q_data)
  );

  // Repack the queued request onto the output stream.
  assign m_axis_tvalid = q_valid;
  assign m_axis_tuser  = q_data[8];
  assign m_axis_tlast  = q_data[9];
  assign m_axis_tdata  = {1'b0, 64'(q_data[Rw-1:17]), q_data[16:10], q_data[7:0]};

endmodule

>>> bench/websocket_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// Frame deframer testbench
// Streams directed and random frame buffers into the deframer, predicts every
// output request from a behavioural parser model or a written row value and
// compares each field. The receiver stalls randomly and once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam int CyclePeriod = 12;
  localparam int CycleLimit  = 400000;

  typedef struct packed {
    logic [63:0] frame_len;
    logic [3:0]  opcode;
    logic        fin;
    logic [1:0]  status;
    logic        done_res;
    logic        has_byte;
    logic [7:0]  out_byte;
  } deframe_res_t;

  typedef struct {
    logic [7:0]   data_byte;
    logic         eob;
    logic         typed;
    deframe_res_t res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Parser state mirrored by the predictor
  phase_e      pr_phase;
  logic        pr_fin;
  logic [3:0]  pr_opcode;
  logic        pr_masked;
  logic [63:0] pr_length;
  logic [2:0]  pr_hdr_cnt;
  logic [31:0] pr_key;
  logic [63:0] pr_pay_cnt;
  logic        pr_close;

  deframe_res_t pending_results[$];
  int           fail_count;
  int           cycle_count;
  bit           stim_done;
  bit           long_hold;
  stim_row_t    rows[$];
  logic [7:0]   buf_bytes[$];

  websocket_frame_deframer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CyclePeriod / 2) clk_i = ~clk_i;
  end

  function automatic void parser_clear();
    pr_phase   = PH_HDR0;
    pr_fin     = 1'b0;
    pr_opcode  = '0;
    pr_masked  = 1'b0;
    pr_length  = '0;
    pr_hdr_cnt = '0;
    pr_key     = '0;
    pr_pay_cnt = '0;
    pr_close   = 1'b0;
  endfunction

  function automatic void end_of_header();
    pr_hdr_cnt = '0;
    if (pr_masked) begin
      pr_phase = PH_KEY;
    end else begin
      pr_phase = (pr_length == 0) ? PH_TRAIL : PH_PAYLOAD;
    end
  endfunction

  // Advance the parser by one byte; returns 1 when an output request results.
  function automatic bit deframe_byte(input logic [7:0] b, input logic eob,
                                      output deframe_res_t r);
    bit emit;
    bit short_buf;
    logic [7:0] ob;
    emit = 0;
    short_buf = 0;
    ob = '0;
    case (pr_phase)
      PH_HDR0: begin
        pr_fin = b[7];
        pr_opcode = b[3:0];
        if (eob) begin
          short_buf = 1;
        end else if (pr_opcode == OpcClose) begin
          pr_close = 1'b1;
          pr_phase = PH_TRAIL;
        end else begin
          pr_phase = PH_HDR1;
        end
      end
      PH_HDR1: begin
        pr_masked = b[7];
        pr_length = {57'd0, b[6:0]};
        pr_hdr_cnt = '0;
        if (b[6:0] == LenExt16) begin
          pr_length = '0;
          pr_phase = PH_EXT16;
        end else if (b[6:0] == LenExt64) begin
          pr_length = '0;
          pr_phase = PH_EXT64;
        end else begin
          end_of_header();
        end
      end
      PH_EXT16, PH_EXT64: begin
        pr_length = {pr_length[55:0], b};
        if (pr_hdr_cnt == ((pr_phase == PH_EXT16) ? 3'd1 : 3'd7)) end_of_header();
        else pr_hdr_cnt = pr_hdr_cnt + 3'd1;
      end
      PH_KEY: begin
        pr_key = {pr_key[23:0], b};
        if (pr_hdr_cnt == 3'd3) begin
          pr_hdr_cnt = '0;
          pr_phase = (pr_length == 0) ? PH_TRAIL : PH_PAYLOAD;
        end else begin
          pr_hdr_cnt = pr_hdr_cnt + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        ob = pr_masked ? (b ^ pr_key[(3 - pr_pay_cnt[1:0]) * 8 +: 8]) : b;
        emit = 1;
        pr_pay_cnt = pr_pay_cnt + 64'd1;
        if (pr_pay_cnt == pr_length) pr_phase = PH_TRAIL;
      end
      default: ;
    endcase
    r = '0;
    if (!emit && !eob) return 0;
    r.out_byte = ob;
    r.has_byte = emit;
    r.done_res = eob;
    if (!eob) r.status = ST_COMPLETE;
    else if (short_buf) r.status = ST_INCOMPLETE;
    else if (pr_close) r.status = ST_CLOSE;
    else r.status = (pr_phase == PH_TRAIL) ? ST_COMPLETE : ST_INCOMPLETE;
    r.fin = pr_fin;
    r.opcode = pr_opcode;
    r.frame_len = pr_length;
    if (eob) parser_clear();
    return 1;
  endfunction

  // Build a mostly well-formed random frame into buf_bytes, with random ending.
  task automatic build_frame();
    int plen;
    int kind;
    int cut;
    int total;
    bit masked;
    logic [31:0] key;
    logic [7:0] frame[$];
    frame = {};
    kind = $urandom_range(0, 9);
    masked = $urandom_range(0, 1);
    key = $urandom;
    plen = $urandom_range(0, 12);
    frame = {frame, {$urandom_range(0, 1) == 1, 3'($urandom), 4'($urandom)}};
    if (kind < 6) begin
      frame = {frame, {masked, 7'(plen)}};
    end else if (kind < 8) begin
      frame = {frame, {masked, LenExt16}};
      frame = {frame, 8'd0};
      frame = {frame, 8'(plen)};
    end else begin
      frame = {frame, {masked, LenExt64}};
      for (int i = 0; i < 7; i++) frame = {frame, 8'(i == 0 ? $urandom : 0)};
      frame = {frame, 8'(plen)};
    end
    // Top byte of the wide length is random: keep payload short by truncating.
    if (masked) for (int i = 3; i >= 0; i--) frame = {frame, key[i*8 +: 8]};
    for (int i = 0; i < plen; i++) frame = {frame, 8'($urandom)};
    total = frame.size();
    cut = $urandom_range(0, 9);
    if (cut < 2) begin
      total = $urandom_range(1, frame.size());
    end else if (cut < 4) begin
      for (int i = 0; i < $urandom_range(1, 4); i++) frame = {frame, 8'($urandom)};
      total = frame.size();
    end
    buf_bytes = {};
    for (int i = 0; i < total; i++) buf_bytes = {buf_bytes, frame[i]};
  endtask

  task automatic add_row(input logic [7:0] b, input logic e, input logic typed,
                         input deframe_res_t r);
    stim_row_t s;
    s.data_byte = b;
    s.eob = e;
    s.typed = typed;
    s.res = r;
    rows = {rows, s};
  endtask

  // Offer one byte and wait until it is accepted.
  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= e;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender with prediction at acceptance
  initial begin
    deframe_res_t r;
    deframe_res_t z;
    int sent;
    bit hold_issued;
    z = '0;
    hold_issued = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni = 1'b0;
    fail_count = 0;
    stim_done = 0;
    long_hold = 0;
    parser_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-byte buffer, even with the close opcode
    r = z; r.done_res = 1; r.status = ST_INCOMPLETE; r.fin = 1; r.opcode = OpcClose;
    add_row(8'h88, 1, 1, r);
    r = z; r.done_res = 1; r.status = ST_INCOMPLETE; r.opcode = 4'hF;
    add_row(8'h7F, 1, 1, r);
    // Close opcode: remainder ignored, status close
    add_row(8'h08, 0, 0, z);
    add_row(8'hFF, 0, 0, z);
    r = z; r.done_res = 1; r.status = ST_CLOSE; r.opcode = OpcClose;
    add_row(8'h00, 1, 1, r);
    // Zero-length frame plus trailing byte
    add_row(8'h81, 0, 0, z);
    add_row(8'h00, 0, 0, z);
    r = z; r.done_res = 1; r.status = ST_COMPLETE; r.fin = 1; r.opcode = 4'h1;
    add_row(8'hAB, 1, 1, r);
    // Masked 2-byte payload, 16-bit length form
    add_row(8'h02, 0, 0, z);
    add_row(8'hFE, 0, 0, z);
    add_row(8'h00, 0, 0, z);
    add_row(8'h02, 0, 0, z);
    add_row(8'hFF, 0, 0, z);
    add_row(8'h01, 0, 0, z);
    add_row(8'h80, 0, 0, z);
    add_row(8'h55, 0, 0, z);
    add_row(8'h00, 0, 0, z);
    add_row(8'hFF, 1, 0, z);
    // Wide 64-bit length, all ones, buffer ends in payload
    add_row(8'h80, 0, 0, z);
    add_row(8'h7F, 0, 0, z);
    for (int i = 0; i < 8; i++) add_row(8'hFF, 0, 0, z);
    add_row(8'h12, 1, 0, z);

    // Typed rows are checked against their written value, the rest against
    // the predictor.
    foreach (rows[i]) begin
      send_byte(rows[i].data_byte, rows[i].eob);
      if (deframe_byte(rows[i].data_byte, rows[i].eob, r)) begin
        if (rows[i].typed) pending_results = {pending_results, rows[i].res};
        else pending_results = {pending_results, r};
      end
    end

    sent = 0;
    while (sent < 550) begin
      if ($urandom_range(0, 9) == 0) begin
        buf_bytes = {};
        for (int i = 0; i < $urandom_range(1, 6); i++)
          buf_bytes = {buf_bytes, 8'($urandom)};
      end else begin
        build_frame();
      end
      if (sent > 150 && !hold_issued) begin
        long_hold = 1;
        hold_issued = 1;
      end
      foreach (buf_bytes[i]) begin
        send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
        if (deframe_byte(buf_bytes[i], i == buf_bytes.size() - 1, r))
          pending_results = {pending_results, r};
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1;
  end

  // Receiver with random stalls and one long hold-off
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare every accepted output request with the oldest prediction
  always @(posedge clk_i) begin
    deframe_res_t act;
    deframe_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = {m_axis_tdata[78:15], m_axis_tdata[14:11], m_axis_tdata[10],
             m_axis_tdata[9:8], m_axis_tlast, m_axis_tuser, m_axis_tdata[7:0]};
      if (pending_results.size() == 0) begin
        $error("unexpected output request %h", act);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (act.out_byte !== exp_r.out_byte) begin
          $error("out_byte exp %h got %h", exp_r.out_byte, act.out_byte); fail_count++;
        end
        if (act.has_byte !== exp_r.has_byte) begin
          $error("has_byte exp %h got %h", exp_r.has_byte, act.has_byte); fail_count++;
        end
        if (act.done_res !== exp_r.done_res) begin
          $error("done_res exp %h got %h", exp_r.done_res, act.done_res); fail_count++;
        end
        if (act.status !== exp_r.status) begin
          $error("status exp %h got %h", exp_r.status, act.status); fail_count++;
        end
        if (act.fin !== exp_r.fin) begin
          $error("fin exp %h got %h", exp_r.fin, act.fin); fail_count++;
        end
        if (act.opcode !== exp_r.opcode) begin
          $error("opcode exp %h got %h", exp_r.opcode, act.opcode); fail_count++;
        end
        if (act.frame_len !== exp_r.frame_len) begin
          $error("frame_len exp %h got %h", exp_r.frame_len, act.frame_len);
          fail_count++;
        end
      end
    end
  end

  // Run end and timeout
  initial begin
    cycle_count = 0;
    while (!(stim_done && pending_results.size() == 0) && cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
    end else begin
      repeat (20) @(posedge clk_i);
      if (fail_count == 0 && pending_results.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule
